[hdl/tlb_pkg.sv]
// Shared types and codes for the fully associative TLB with FIFO replacement.
package tlb_pkg;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_FILL   = 1'b1;

  localparam int ADDR_W = 32;
  localparam int TIME_W = 32;
  localparam int SLOT_W = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RESULT,
    ST_FILL,
    ST_SCAN,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic load;
    logic match;
    logic emit;
    logic pick_free;
    logic scan_start;
    logic scan;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic has_free;
    logic scan_done;
  } status_t;

endpackage

[hdl/tlb_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module tlb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/tlb_controller.sv]
// Control state machine that sequences lookups, free-slot fills and the oldest-entry scan.
module tlb_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              action,
  input  tlb_pkg::status_t  status,
  output tlb_pkg::cmd_t     cmd,
  output logic              busy
);

  tlb_pkg::state_t state;
  tlb_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tlb_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (action == tlb_pkg::ACT_FILL) ? tlb_pkg::ST_FILL : tlb_pkg::ST_MATCH;
        end
      end
      tlb_pkg::ST_MATCH:  state_next = tlb_pkg::ST_RESULT;
      tlb_pkg::ST_RESULT: state_next = tlb_pkg::ST_IDLE;
      tlb_pkg::ST_FILL: begin
        state_next = status.has_free ? tlb_pkg::ST_WRITE : tlb_pkg::ST_SCAN;
      end
      tlb_pkg::ST_SCAN: begin
        if (status.scan_done) begin
          state_next = tlb_pkg::ST_WRITE;
        end
      end
      tlb_pkg::ST_WRITE:  state_next = tlb_pkg::ST_IDLE;
      default:            state_next = tlb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      tlb_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      tlb_pkg::ST_MATCH:  cmd.match = 1'b1;
      tlb_pkg::ST_RESULT: cmd.emit = 1'b1;
      tlb_pkg::ST_FILL: begin
        cmd.pick_free  = status.has_free;
        cmd.scan_start = ~status.has_free;
      end
      tlb_pkg::ST_SCAN:   cmd.scan = 1'b1;
      tlb_pkg::ST_WRITE:  cmd.write = 1'b1;
      default:            busy = 1'b1;
    endcase
  end

endmodule

[hdl/tlb_datapath.sv]
// Entry storage, tag compare, victim scan and result registers of the TLB.
module tlb_datapath #(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_SIZE   = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tlb_pkg::cmd_t               cmd,
  output tlb_pkg::status_t            status,
  input  logic                        action,
  input  logic [tlb_pkg::ADDR_W-1:0]  virtual_address,
  input  logic [tlb_pkg::ADDR_W-1:0]  physical_address,
  input  logic [tlb_pkg::TIME_W-1:0]  timestamp,
  output logic                        done,
  output logic                        hit,
  output logic [tlb_pkg::ADDR_W-1:0]  translated_address,
  output logic [tlb_pkg::SLOT_W-1:0]  slot_written
);

  // The page size is a power of two, so the page number and offset are bit fields.
  localparam int OFF_W  = $clog2(PAGE_SIZE);
  localparam int PAGE_W = tlb_pkg::ADDR_W - OFF_W;
  localparam int IDX_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(TLB_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TLB_ENTRIES);
  localparam int SLOT_W_EXT = tlb_pkg::SLOT_W + IDX_W;

  logic                      req_action;
  logic [PAGE_W-1:0]         req_page;
  logic [OFF_W-1:0]          req_offset;
  logic [PAGE_W-1:0]         req_frame;
  logic [tlb_pkg::TIME_W-1:0] req_time;

  logic [TLB_ENTRIES-1:0]    valid;
  logic [PAGE_W-1:0]         page [TLB_ENTRIES];

  logic                      match_any;
  logic [IDX_W-1:0]          match_idx;
  logic                      free_any;
  logic [IDX_W-1:0]          free_idx;

  logic                      hit_reg;
  logic [IDX_W-1:0]          victim;
  logic [CNT_W-1:0]          cnt;
  logic                      pend;
  logic [IDX_W-1:0]          pend_idx;
  logic                      have_best;
  logic [tlb_pkg::TIME_W-1:0] best_time;

  logic [PAGE_W-1:0]         frame_rd;
  logic [tlb_pkg::TIME_W-1:0] time_rd;
  logic [SLOT_W_EXT-1:0]     slot_ext;

  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    free_any  = 1'b0;
    free_idx  = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && (page[i] == req_page)) begin
        match_any = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (!valid[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign status.has_free  = free_any;
  assign status.scan_done = (cnt == CNT_END) && !pend;
  assign slot_ext         = {{tlb_pkg::SLOT_W{1'b0}}, victim};

  tlb_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (TLB_ENTRIES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (victim),
    .wdata (req_frame),
    .raddr (match_idx),
    .rdata (frame_rd)
  );

  tlb_ram #(
    .WIDTH (tlb_pkg::TIME_W),
    .DEPTH (TLB_ENTRIES)
  ) u_time_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (victim),
    .wdata (req_time),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (time_rd)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_action <= action;
      req_page   <= virtual_address[tlb_pkg::ADDR_W-1:OFF_W];
      req_offset <= virtual_address[OFF_W-1:0];
      req_frame  <= physical_address[tlb_pkg::ADDR_W-1:OFF_W];
      req_time   <= timestamp;
    end
    if (cmd.match) begin
      hit_reg <= match_any && (req_action == tlb_pkg::ACT_LOOKUP);
    end
    if (cmd.pick_free) begin
      victim <= free_idx;
    end
    if (cmd.scan && pend && (!have_best || (time_rd < best_time))) begin
      best_time <= time_rd;
      victim    <= pend_idx;
    end
    if (cmd.scan && (cnt != CNT_END)) begin
      pend_idx <= cnt[IDX_W-1:0];
    end
    if (cmd.write) begin
      page[victim] <= req_page;
    end
    if (cmd.emit) begin
      hit                <= hit_reg;
      translated_address <= hit_reg ? {frame_rd, req_offset} : '0;
      slot_written       <= '0;
    end else if (cmd.write) begin
      hit                <= 1'b0;
      translated_address <= '0;
      slot_written       <= slot_ext[tlb_pkg::SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      done      <= 1'b0;
      cnt       <= '0;
      pend      <= 1'b0;
      have_best <= 1'b0;
    end else begin
      done <= cmd.emit | cmd.write;
      if (cmd.write) begin
        valid[victim] <= 1'b1;
      end
      if (cmd.scan_start) begin
        cnt       <= '0;
        pend      <= 1'b0;
        have_best <= 1'b0;
      end else if (cmd.scan) begin
        if (cnt != CNT_END) begin
          pend <= 1'b1;
          cnt  <= CNT_W'(cnt + 1'b1);
        end else begin
          pend <= 1'b0;
        end
        if (pend) begin
          have_best <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/tlb_lookup_fifo_fill.sv]
// Top level of the fully associative TLB with FIFO replacement.
//
// A request is taken at a rising edge where start is high and busy is low.
// The action port selects a lookup or a fill; virtual_address, physical_address
// and timestamp travel with it. Every request gives exactly one result, shown
// for one cycle with done high, together with hit, translated_address and
// slot_written. The receiver cannot stall, so a result is simply presented.
// A lookup compares all tags in parallel in state MATCH, reads the frame from
// a small RAM and registers its result in state RESULT; busy is high in both
// states. A fill into a free entry goes through FILL and WRITE. When every entry
// is valid, a fill reads the fill dates one per cycle from the date RAM to find
// the oldest entry in state SCAN before WRITE. The next request may be taken in
// the cycle its result is shown.
// Reset clears all valid bits and the controller; no clearing pass is needed.
// PAGE_SIZE must be a power of two.
module tlb_lookup_fifo_fill #(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_SIZE   = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        action,
  input  logic [tlb_pkg::ADDR_W-1:0]  virtual_address,
  input  logic [tlb_pkg::ADDR_W-1:0]  physical_address,
  input  logic [tlb_pkg::TIME_W-1:0]  timestamp,
  output logic                        done,
  output logic                        hit,
  output logic [tlb_pkg::ADDR_W-1:0]  translated_address,
  output logic [tlb_pkg::SLOT_W-1:0]  slot_written
);

  tlb_pkg::cmd_t    cmd;
  tlb_pkg::status_t status;

  tlb_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  tlb_datapath #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_SIZE   (PAGE_SIZE)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .action             (action),
    .virtual_address    (virtual_address),
    .physical_address   (physical_address),
    .timestamp          (timestamp),
    .done               (done),
    .hit                (hit),
    .translated_address (translated_address),
    .slot_written       (slot_written)
  );

endmodule
